// ----- src/assert_macros.svh -----
// Assertion macros shared by the frustum box cull RTL.
// Each macro expects clk and rst to be in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define CHECK_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, when seen, forces another one on the next edge.
`define CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/fbc_pkg.sv -----
// Package for the frustum box cull block: item type, opcodes and constants.
// Used by fbc_cell and frustum_box_cull_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package fbc_pkg;

  // Number of clip planes, one cell each.
  localparam int unsigned PLANE_COUNT = 6;

  // Matrix row that every plane combines with one of rows 0, 1 or 2.
  localparam logic [1:0] W_ROW = 2'd3;

  // Item operation.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_BOX  = 1'b1
  } op_t;

  // One item as it travels down the row of plane cells.
  typedef struct packed {
    op_t                op;
    logic [3:0]         matrix_index;
    logic signed [31:0] matrix_value;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic               ok;
  } item_t;

endpackage

`default_nettype wire

// ----- src/frustum_box_cull_top.sv -----
// An accepted box item reaches in_view through six cells of three stages each,
// then the output register. The block accepts one item per cycle, loads and
// boxes alike, while out_stall does not hold the chain.
// Reset clears the view matrix to zeros and empties all stages; load items
// give no result and leave the chain at its end.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module frustum_box_cull_top import fbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [3:0]         matrix_index,
  input  logic signed [31:0] matrix_value,
  input  logic signed [31:0] min_x,
  input  logic signed [31:0] min_y,
  input  logic signed [31:0] min_z,
  input  logic signed [31:0] max_x,
  input  logic signed [31:0] max_y,
  input  logic signed [31:0] max_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               in_view
);

  logic  chain_valid [PLANE_COUNT + 1];
  logic  chain_ready [PLANE_COUNT + 1];
  item_t chain_item  [PLANE_COUNT + 1];
  logic  end_valid, end_ready, end_is_box;

  // Build the entering item; it starts out visible.
  always_comb begin
    chain_item[0].op           = op_t'(opcode);
    chain_item[0].matrix_index = matrix_index;
    chain_item[0].matrix_value = matrix_value;
    chain_item[0].min_x        = min_x;
    chain_item[0].min_y        = min_y;
    chain_item[0].min_z        = min_z;
    chain_item[0].max_x        = max_x;
    chain_item[0].max_y        = max_y;
    chain_item[0].max_z        = max_z;
    chain_item[0].ok           = 1'b1;
  end
  assign chain_valid[0] = in_valid;
  assign in_stall       = !chain_ready[0];

  // Row of plane cells.
  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
    fbc_cell #(
      .PLANE_IDX(g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (chain_valid[g]),
      .in_item  (chain_item[g]),
      .in_ready (chain_ready[g]),
      .out_valid(chain_valid[g + 1]),
      .out_item (chain_item[g + 1]),
      .out_ready(chain_ready[g + 1])
    );
  end

  // End of the chain: loads are dropped, boxes go to the output register.
  assign end_valid  = chain_valid[PLANE_COUNT];
  assign end_is_box = chain_item[PLANE_COUNT].op == OP_BOX;
  assign end_ready  = !end_is_box || !out_valid || !out_stall;
  assign chain_ready[PLANE_COUNT] = end_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (end_valid && end_is_box && end_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_valid && end_is_box && end_ready) begin
      in_view <= chain_item[PLANE_COUNT].ok;
    end
  end

  `CHECK_NEXT(a_load_no_result, end_valid && !end_is_box && !out_valid, !out_valid,
              "load item produced a result")
  `CHECK_NEXT(a_out_holds, out_valid && out_stall, out_valid, "stalled result dropped")
  `CHECK_NEXT(a_view_holds, out_valid && out_stall, $stable(in_view), "stalled in_view changed")

endmodule

`default_nettype wire

// ----- src/fbc_cell.sv -----
// One plane cell: holds the matrix elements and plane of one clip plane and tests boxes.
// Depends on fbc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fbc_cell import fbc_pkg::*; #(
  parameter int unsigned PLANE_IDX = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_ready,
  output logic  out_valid,
  output item_t out_item,
  input  logic  out_ready
);

  // Plane k combines row 3 with row k/2, added for even k and subtracted for odd k.
  localparam logic [1:0] ROW = 2'(PLANE_IDX >> 1);
  localparam logic       SUB = 1'(PLANE_IDX & 1);

  // Local copy of the matrix rows this plane needs, and the plane built from them.
  logic signed [31:0] w_elem [4];
  logic signed [31:0] r_elem [4];
  logic signed [32:0] plane [4];
  logic signed [31:0] w_next [4];
  logic signed [31:0] r_next [4];
  logic signed [32:0] plane_next [4];
  logic               load_en;

  // Stage registers.
  logic               a_valid, b_valid, c_valid;
  item_t              a_item, b_item, c_item;
  logic signed [64:0] prod [3];
  logic signed [64:0] prod_next [3];
  logic signed [31:0] pick [3];
  logic signed [32:0] b_dist;
  logic [65:0]        sum_a, sum_b;
  logic [65:0]        sum_a_next, sum_b_next;
  logic [66:0]        total;
  logic               a_free, b_free, c_free;
  logic               plane_ok;

  // Handshake: a stage takes a new item when it is empty or its item moves on.
  assign c_free   = !c_valid || out_ready;
  assign b_free   = !b_valid || c_free;
  assign a_free   = !a_valid || b_free;
  assign in_ready = a_free;
  assign load_en  = in_valid && a_free && (in_item.op == OP_LOAD);

  // Element update for a passing load, and the plane rebuilt from the new elements.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      w_next[c] = w_elem[c];
      r_next[c] = r_elem[c];
      if (load_en && (in_item.matrix_index[3:2] == 2'(c))) begin
        if (in_item.matrix_index[1:0] == W_ROW) begin
          w_next[c] = in_item.matrix_value;
        end
        if (in_item.matrix_index[1:0] == ROW) begin
          r_next[c] = in_item.matrix_value;
        end
      end
      if (SUB) begin
        plane_next[c] = {w_next[c][31], w_next[c]} - {r_next[c][31], r_next[c]};
      end else begin
        plane_next[c] = {w_next[c][31], w_next[c]} + {r_next[c][31], r_next[c]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 4; c++) begin
        w_elem[c] <= '0;
        r_elem[c] <= '0;
        plane[c]  <= '0;
      end
    end else if (load_en) begin
      w_elem <= w_next;
      r_elem <= r_next;
      plane  <= plane_next;
    end
  end

  // Positive vertex: max corner where the normal component is not negative.
  always_comb begin
    pick[0] = plane[0][32] ? a_item.min_x : a_item.max_x;
    pick[1] = plane[1][32] ? a_item.min_y : a_item.max_y;
    pick[2] = plane[2][32] ? a_item.min_z : a_item.max_z;
    for (int c = 0; c < 3; c++) begin
      prod_next[c] = plane[c] * pick[c];
    end
  end

  // Partial sums: two products, and the third product plus the distance in Q32.32.
  assign sum_a_next = {prod[0][64], prod[0]} + {prod[1][64], prod[1]};
  assign sum_b_next = {prod[2][64], prod[2]} + {{17{b_dist[32]}}, b_dist, 16'b0};
  assign total      = {sum_a[65], sum_a} + {sum_b[65], sum_b};

  // Stage A: item enters the cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && in_valid) begin
      a_item <= in_item;
    end
  end

  // Stage B: normal times vertex products, distance captured with them.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && a_valid) begin
      b_item <= a_item;
      prod   <= prod_next;
      b_dist <= plane[3];
    end
  end

  // Stage C: two partial sums; the final add and sign test feed the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_free) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_free && b_valid) begin
      c_item <= b_item;
      sum_a  <= sum_a_next;
      sum_b  <= sum_b_next;
    end
  end

  always_comb begin
    out_item = c_item;
    if (c_item.op == OP_BOX) begin
      out_item.ok = c_item.ok && !total[66];
    end
  end
  assign out_valid = c_valid;

  // The stored plane always matches the stored elements.
  always_comb begin
    plane_ok = 1'b1;
    for (int c = 0; c < 4; c++) begin
      if (SUB) begin
        plane_ok = plane_ok &&
                   (plane[c] == ({w_elem[c][31], w_elem[c]} - {r_elem[c][31], r_elem[c]}));
      end else begin
        plane_ok = plane_ok &&
                   (plane[c] == ({w_elem[c][31], w_elem[c]} + {r_elem[c][31], r_elem[c]}));
      end
    end
  end

  `CHECK_ALWAYS(a_plane_match, plane_ok, "plane out of step with matrix elements")
  `CHECK_NEXT(a_stage_a_holds, a_valid && !b_free, a_valid, "stage A item lost while blocked")
  `CHECK_NEXT(a_stage_c_holds, c_valid && !out_ready, c_valid, "stage C item lost while blocked")

endmodule

`default_nettype wire
